// ----- hw/rtl/ptoe_pkg.sv -----
package ptoe_pkg;

  localparam int ID_W   = 64;
  localparam int IP_W   = 32;
  localparam int PORT_W = 16;
  localparam int TIME_W = 32;
  localparam int SLOT_W = 4;
  localparam int LIVE_W = 5;
  localparam int DATA_W = 32;
  localparam int ADDR_W = 3;

  localparam logic [TIME_W-1:0] FRESH_RESET = 32'd45000;

  // register index taken from paddr[2]
  localparam logic REG_FRESH_LIMIT = 1'b0;

  typedef enum logic [1:0] {
    KIND_LEARN  = 2'd0,
    KIND_LOOKUP = 2'd1,
    KIND_COUNT  = 2'd2,
    KIND_READ   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN
  } state_t;

  typedef struct packed {
    kind_t               kind;
    logic [ID_W-1:0]     node_id;
    logic [IP_W-1:0]     peer_ip;
    logic [PORT_W-1:0]   peer_port;
    logic [TIME_W-1:0]   now_ms;
    logic [SLOT_W-1:0]   slot;
  } in_item_t;

  typedef struct packed {
    logic                hit;
    logic                is_fresh;
    logic [ID_W-1:0]     found_id;
    logic [IP_W-1:0]     found_ip;
    logic [PORT_W-1:0]   found_port;
    logic [LIVE_W-1:0]   live_count;
    logic                replaced;
  } out_item_t;

  // query token that walks the cell row, gathering what each cell contributes
  typedef struct packed {
    kind_t               kind;
    logic [ID_W-1:0]     id;
    logic [TIME_W-1:0]   now;
    logic [SLOT_W-1:0]   slot;
    logic                found;
    logic [IP_W-1:0]     f_ip;
    logic [PORT_W-1:0]   f_port;
    logic [TIME_W-1:0]   f_seen;
    logic [TIME_W-1:0]   best_seen;
    logic                rd_hit;
    logic [ID_W-1:0]     rd_id;
    logic [IP_W-1:0]     rd_ip;
    logic [PORT_W-1:0]   rd_port;
  } scan_tok_t;

  // entry write broadcast to the row
  typedef struct packed {
    logic                en;
    logic                new_id;
    logic [ID_W-1:0]     id;
    logic [IP_W-1:0]     ip;
    logic [PORT_W-1:0]   port;
    logic [TIME_W-1:0]   seen;
  } wr_t;

endpackage

// ----- hw/rtl/ptoe_if.sv -----
interface ptoe_in_if import ptoe_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface ptoe_out_if import ptoe_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- hw/rtl/ptoe_cell.sv -----
module ptoe_cell import ptoe_pkg::*; #(
  parameter int ID_BITS = 64,
  parameter int IDX_W   = 4,
  parameter int CNT_W   = 5,
  parameter int INDEX   = 0
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [CNT_W-1:0]    entry_count,
  input  logic [TIME_W-1:0]   fresh_limit,
  input  logic                vld_in,
  input  scan_tok_t           tok_in,
  input  logic [IDX_W-1:0]    fidx_in,
  input  logic [IDX_W-1:0]    bidx_in,
  input  logic [CNT_W-1:0]    live_in,
  output logic                vld_out,
  output scan_tok_t           tok_out,
  output logic [IDX_W-1:0]    fidx_out,
  output logic [IDX_W-1:0]    bidx_out,
  output logic [CNT_W-1:0]    live_out,
  input  wr_t                 wr,
  input  logic [IDX_W-1:0]    wr_idx
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);
  localparam logic [CNT_W-1:0] MY_CNT = CNT_W'(INDEX);

  logic [ID_BITS-1:0] id_q;
  logic [IP_W-1:0]    ip_q;
  logic [PORT_W-1:0]  port_q;
  logic [TIME_W-1:0]  seen_q;

  logic               in_use;
  logic [ID_W-1:0]    id_ext;
  logic [TIME_W-1:0]  age;
  scan_tok_t          tok_next;
  logic [IDX_W-1:0]   fidx_next;
  logic [IDX_W-1:0]   bidx_next;
  logic [CNT_W-1:0]   live_next;

  assign in_use = MY_CNT < entry_count;
  assign id_ext = ID_W'(id_q);
  assign age    = tok_in.now - seen_q;

  always_comb begin
    tok_next  = tok_in;
    fidx_next = fidx_in;
    bidx_next = bidx_in;
    live_next = live_in;
    if (in_use && !tok_in.found && id_ext == tok_in.id) begin
      tok_next.found  = 1'b1;
      tok_next.f_ip   = ip_q;
      tok_next.f_port = port_q;
      tok_next.f_seen = seen_q;
      fidx_next       = MY_IDX;
    end
    // oldest entry, strict compare so the lower index keeps ties
    if (INDEX == 0 || seen_q < tok_in.best_seen) begin
      tok_next.best_seen = seen_q;
      bidx_next          = MY_IDX;
    end
    if (in_use && age < fresh_limit) begin
      live_next = live_in + CNT_W'(1);
    end
    if (in_use && 32'(tok_in.slot) == 32'(INDEX)) begin
      tok_next.rd_hit  = 1'b1;
      tok_next.rd_id   = id_ext;
      tok_next.rd_ip   = ip_q;
      tok_next.rd_port = port_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_out <= 1'b0;
    end else begin
      vld_out <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    tok_out  <= tok_next;
    fidx_out <= fidx_next;
    bidx_out <= bidx_next;
    live_out <= live_next;
  end

  always_ff @(posedge clk) begin
    if (wr.en && wr_idx == MY_IDX) begin
      ip_q   <= wr.ip;
      port_q <= wr.port;
      seen_q <= wr.seen;
      if (wr.new_id) begin
        id_q <= wr.id[ID_BITS-1:0];
      end
    end
  end

endmodule

// ----- hw/rtl/peer_table_oldest_eviction.sv -----
// Peer table, oldest-entry replacement, built as a row of MAX_ENTRIES entry cells.
// The query token enters cell 0 on the input transfer and walks one cell per cycle;
// a learn writes its entry as the token leaves the row, the result is registered, and
// the drain step loads it once the output is free; only then is a new item taken.
// Reset (rst, synchronous): table empty, fresh limit 45000, no result pending.
// Entry contents are not reset; only entries below the fill count are ever seen.
module peer_table_oldest_eviction import ptoe_pkg::*; #(
  parameter int MAX_ENTRIES = 16,
  parameter int ID_BITS     = 64
) (
  input  logic               clk,
  input  logic               rst,
  ptoe_in_if.sink            in,
  ptoe_out_if.source         out,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready
);

  localparam int IDX_W = $clog2(MAX_ENTRIES);
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam logic [CNT_W-1:0] FULL = CNT_W'(MAX_ENTRIES);

  // ---------------------------------------------------------------------------
  // Configuration: single register, fresh limit in ms
  // ---------------------------------------------------------------------------
  logic [TIME_W-1:0] fresh_limit;
  logic              cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && paddr[2] == REG_FRESH_LIMIT;
  assign prdata = (paddr[2] == REG_FRESH_LIMIT) ? fresh_limit : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      fresh_limit <= FRESH_RESET;
    end else if (cfg_wr) begin
      fresh_limit <= pwdata;
    end
  end

  // ---------------------------------------------------------------------------
  // Cell row. Position k feeds cell k; cell k drives position k+1.
  // ---------------------------------------------------------------------------
  logic [MAX_ENTRIES:0] vld;
  scan_tok_t            tok  [0:MAX_ENTRIES];
  logic [IDX_W-1:0]     fidx [0:MAX_ENTRIES];
  logic [IDX_W-1:0]     bidx [0:MAX_ENTRIES];
  logic [CNT_W-1:0]     live [0:MAX_ENTRIES];

  logic [CNT_W-1:0]     entry_count;
  logic [CNT_W-1:0]     entry_count_next;
  wr_t                  wr;
  logic [IDX_W-1:0]     wr_idx;

  state_t               state;
  state_t               state_next;
  out_item_t            res;
  out_item_t            res_next;
  logic                 take_in;
  logic                 finish;
  logic                 load_out;

  assign take_in = in.valid && in.ready;

  // token injection: a fresh query enters cell 0 on the input transfer
  assign vld[0] = take_in;
  always_comb begin
    tok[0]           = '0;
    tok[0].kind      = in.data.kind;
    tok[0].id        = ID_W'(in.data.node_id[ID_BITS-1:0]);
    tok[0].now       = in.data.now_ms;
    tok[0].slot      = in.data.slot;
    tok[0].best_seen = '1;
  end
  assign fidx[0] = '0;
  assign bidx[0] = '0;
  assign live[0] = '0;

  for (genvar k = 0; k < MAX_ENTRIES; k++) begin : g_cell
    ptoe_cell #(
      .ID_BITS (ID_BITS),
      .IDX_W   (IDX_W),
      .CNT_W   (CNT_W),
      .INDEX   (k)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .entry_count (entry_count),
      .fresh_limit (fresh_limit),
      .vld_in      (vld[k]),
      .tok_in      (tok[k]),
      .fidx_in     (fidx[k]),
      .bidx_in     (bidx[k]),
      .live_in     (live[k]),
      .vld_out     (vld[k+1]),
      .tok_out     (tok[k+1]),
      .fidx_out    (fidx[k+1]),
      .bidx_out    (bidx[k+1]),
      .live_out    (live[k+1]),
      .wr          (wr),
      .wr_idx      (wr_idx)
    );
  end

  // ---------------------------------------------------------------------------
  // Token leaving the row: pick the write slot for a learn and build the result
  // ---------------------------------------------------------------------------
  scan_tok_t         last;
  logic              full;
  logic [TIME_W-1:0] f_age;
  in_item_t          held;

  assign last  = tok[MAX_ENTRIES];
  assign full  = entry_count == FULL;
  assign f_age = last.now - last.f_seen;
  assign finish = (state == ST_SCAN) && vld[MAX_ENTRIES];

  always_comb begin
    res_next         = '0;
    entry_count_next = entry_count;
    wr               = '0;
    wr.id            = last.id;
    wr.ip            = held.peer_ip;
    wr.port          = held.peer_port;
    wr.seen          = last.now;
    wr_idx           = fidx[MAX_ENTRIES];
    unique case (last.kind)
      KIND_LEARN: begin
        wr.en     = finish;
        wr.new_id = !last.found;
        if (!last.found) begin
          if (full) begin
            // table full: evict the smallest last-seen time
            wr_idx            = bidx[MAX_ENTRIES];
            res_next.replaced = 1'b1;
          end else begin
            wr_idx           = entry_count[IDX_W-1:0];
            entry_count_next = entry_count + CNT_W'(1);
          end
        end
      end
      KIND_LOOKUP: begin
        if (last.found) begin
          res_next.hit        = 1'b1;
          res_next.is_fresh   = f_age <= fresh_limit;
          res_next.found_ip   = last.f_ip;
          res_next.found_port = last.f_port;
        end
      end
      KIND_COUNT: begin
        res_next.live_count = LIVE_W'(live[MAX_ENTRIES]);
      end
      KIND_READ: begin
        if (last.rd_hit) begin
          res_next.hit        = 1'b1;
          res_next.found_id   = last.rd_id;
          res_next.found_ip   = last.rd_ip;
          res_next.found_port = last.rd_port;
        end
      end
      default: ;
    endcase
  end

  // learn data is not held on the input item until the token returns, so keep a copy
  always_ff @(posedge clk) begin
    if (take_in) begin
      held <= in.data;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer: one item in the row at a time
  // ---------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (take_in)  state_next = ST_SCAN;
      ST_SCAN:  if (finish)   state_next = ST_DRAIN;
      ST_DRAIN: if (load_out) state_next = ST_IDLE;
      default:                state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in.ready = 1'b0;
    load_out = 1'b0;
    unique case (state)
      ST_IDLE:  in.ready = 1'b1;
      ST_SCAN:  ;
      ST_DRAIN: load_out = !out.valid || out.ready;
      default:  ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      entry_count <= '0;
    end else begin
      state <= state_next;
      if (finish) begin
        entry_count <= entry_count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      res <= res_next;
    end
  end

  // output register: parts the row from a stalled consumer
  always_ff @(posedge clk) begin
    if (rst) begin
      out.valid <= 1'b0;
    end else if (load_out) begin
      out.valid <= 1'b1;
    end else if (out.ready) begin
      out.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out.data <= res;
    end
  end

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  a_one_token: assert property (@(posedge clk) disable iff (rst)
    $countones(vld) <= 1)
    else $error("more than one query in the cell row");

  a_token_in_scan: assert property (@(posedge clk) disable iff (rst)
    vld[MAX_ENTRIES] |-> state == ST_SCAN)
    else $error("query left the row outside the scan state");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= FULL)
    else $error("fill count above table size");

  a_count_grow: assert property (@(posedge clk) disable iff (rst)
    (finish && last.kind == KIND_LEARN && !last.found && !full)
      |=> entry_count == $past(entry_count) + CNT_W'(1))
    else $error("new learn did not grow the table");

endmodule

// ----- verif/ptoe_tb_pkg.sv -----
package ptoe_tb_pkg;
  import ptoe_pkg::*;

  localparam int TABLE_DEPTH = 16;
  localparam int SHOW_LIMIT  = 10;

  // Mirror of the peer table: predicts each reply and checks it in order.
  class peer_table_mirror;
    logic [ID_W-1:0]   ids   [TABLE_DEPTH];
    logic [IP_W-1:0]   ips   [TABLE_DEPTH];
    logic [PORT_W-1:0] ports [TABLE_DEPTH];
    logic [TIME_W-1:0] seen  [TABLE_DEPTH];
    int unsigned       count;
    logic [TIME_W-1:0] limit;
    out_item_t         awaited[$];
    int unsigned       mismatches;

    function new();
      count      = 0;
      limit      = FRESH_RESET;
      mismatches = 0;
      foreach (ids[i]) begin
        ids[i]   = '0;
        ips[i]   = '0;
        ports[i] = '0;
        seen[i]  = '0;
      end
    endfunction

    function int locate(logic [ID_W-1:0] id);
      for (int i = 0; i < count; i++) begin
        if (ids[i] == id) return i;
      end
      return -1;
    endfunction

    function void take_request(in_item_t it);
      out_item_t         r;
      int                pos;
      int                best;
      logic [TIME_W-1:0] age;
      r = '0;
      case (it.kind)
        KIND_LEARN: begin
          pos = locate(it.node_id);
          if (pos < 0) begin
            if (count >= TABLE_DEPTH) begin
              // oldest by plain unsigned compare, lowest index on a tie
              best = 0;
              for (int i = 1; i < TABLE_DEPTH; i++) begin
                if (seen[i] < seen[best]) best = i;
              end
              pos = best;
              r.replaced = 1'b1;
            end else begin
              pos = count;
              count++;
            end
            ids[pos] = it.node_id;
          end
          ips[pos]   = it.peer_ip;
          ports[pos] = it.peer_port;
          seen[pos]  = it.now_ms;
        end
        KIND_LOOKUP: begin
          pos = locate(it.node_id);
          if (pos >= 0) begin
            age          = it.now_ms - seen[pos];
            r.hit        = 1'b1;
            r.is_fresh   = (age <= limit);
            r.found_ip   = ips[pos];
            r.found_port = ports[pos];
          end
        end
        KIND_COUNT: begin
          for (int i = 0; i < count; i++) begin
            age = it.now_ms - seen[i];
            if (age < limit) r.live_count++;
          end
        end
        default: begin
          if (it.slot < count) begin
            r.hit        = 1'b1;
            r.found_id   = ids[it.slot];
            r.found_ip   = ips[it.slot];
            r.found_port = ports[it.slot];
          end
        end
      endcase
      awaited.push_back(r);
    endfunction

    function void compare(string field, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        mismatches++;
        if (mismatches <= SHOW_LIMIT)
          $display("mismatch on %s: expected %h, got %h", field, want, got);
      end
    endfunction

    function void match_reply(out_item_t got);
      out_item_t want;
      if (awaited.size() == 0) begin
        mismatches++;
        if (mismatches <= SHOW_LIMIT)
          $display("reply with nothing awaited: hit %b ip %h", got.hit, got.found_ip);
        return;
      end
      want = awaited.pop_front();
      compare("hit",        64'(want.hit),        64'(got.hit));
      compare("is_fresh",   64'(want.is_fresh),   64'(got.is_fresh));
      compare("found_id",   64'(want.found_id),   64'(got.found_id));
      compare("found_ip",   64'(want.found_ip),   64'(got.found_ip));
      compare("found_port", 64'(want.found_port), 64'(got.found_port));
      compare("live_count", 64'(want.live_count), 64'(got.live_count));
      compare("replaced",   64'(want.replaced),   64'(got.replaced));
    endfunction
  endclass

endpackage

// ----- verif/tb_peer_table_oldest_eviction.sv -----
module tb_peer_table_oldest_eviction import ptoe_pkg::*, ptoe_tb_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HALF_PERIOD  = 10;
  localparam int RESET_CYCLES = 7;
  // watchdog limit, well above the length of the slowest honest run
  localparam int CYCLE_LIMIT  = 400000;
  localparam int ID_POOL      = 24;    // more ids than slots, so the table evicts
  localparam int PHASES       = 6;
  localparam int PHASE_ITEMS  = 155;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 40;    // idle time after the last reply, before the verdict

  localparam logic [ADDR_W-1:0] FRESH_ADDR = {REG_FRESH_LIMIT, 2'b00};
  // index one past the register list; writes there must be ignored
  localparam logic [ADDR_W-1:0] SPARE_ADDR = {~REG_FRESH_LIMIT, 2'b00};

  logic              clk;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  ptoe_in_if  in_ch ();
  ptoe_out_if out_ch ();

  peer_table_oldest_eviction #(
    .MAX_ENTRIES (TABLE_DEPTH),
    .ID_BITS     (ID_W)
  ) DUT (
    .clk     (clk),
    .rst     (rst),
    .in      (in_ch),
    .out     (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  peer_table_mirror  tbl;
  int                snd_idle_pct;
  int                rcv_idle_pct;
  int                hold_left;     // receiver hold-off, counted down by the receiver
  int                cycle_count;
  logic [TIME_W-1:0] cur_ms;        // running clock of the peers' world
  logic [ID_W-1:0]   id_pool [ID_POOL];

  initial clk = 1'b0;
  always #(HALF_PERIOD) clk = ~clk;

  // Receiver: drops ready at random, or for a whole hold-off stretch.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
      end
    end
  end

  // Reply monitor: values read just after the edge are those the edge sampled.
  initial begin
    forever begin
      @(posedge clk);
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
        tbl.match_reply(out_ch.data);
    end
  end

  // Watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("** peer_table_oldest_eviction: FAILED **");
    $finish;
  end

  task automatic set_idling(int snd, int rcv);
    snd_idle_pct = snd;
    rcv_idle_pct = rcv;
  endtask

  // Offer one request; valid stays high afterwards so back-to-back transfers
  // need no gap. The mirror is updated on the accepting edge.
  task automatic send_item(in_item_t it);
    @(negedge clk);
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= it;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    tbl.take_request(it);
  endtask

  task automatic offer(kind_t k, logic [ID_W-1:0] id, logic [IP_W-1:0] ip,
                       logic [PORT_W-1:0] port, logic [TIME_W-1:0] now,
                       logic [SLOT_W-1:0] slot);
    in_item_t it;
    it.kind      = k;
    it.node_id   = id;
    it.peer_ip   = ip;
    it.peer_port = port;
    it.now_ms    = now;
    it.slot      = slot;
    send_item(it);
  endtask

  // Stop offering and wait until every reply has come back.
  task automatic drain_results();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (tbl.awaited.size() != 0) @(posedge clk);
  endtask

  task automatic reg_check();
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= FRESH_ADDR;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (pready !== 1'b1) @(posedge clk);
    tbl.compare("fresh_limit_ms", 64'(tbl.limit), 64'(prdata));
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Setup then access; the register takes the value on the access edge.
  task automatic reg_write(logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (pready !== 1'b1) @(posedge clk);
    if (addr == FRESH_ADDR) tbl.limit = val;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    reg_check();
  endtask

  // Random request. Mostly ids from a small pool, so learns update and evict
  // and lookups hit; now and then an age pinned right at the fresh limit.
  function automatic in_item_t make_item();
    in_item_t          it;
    int                r;
    int                k;
    logic [TIME_W-1:0] offs;
    r = $urandom_range(0, 99);
    if (r < 40)      it.kind = KIND_LEARN;
    else if (r < 65) it.kind = KIND_LOOKUP;
    else if (r < 80) it.kind = KIND_COUNT;
    else             it.kind = KIND_READ;
    it.node_id   = {$urandom, $urandom};
    it.peer_ip   = $urandom;
    it.peer_port = PORT_W'($urandom);
    it.slot      = SLOT_W'($urandom);

    r = $urandom_range(0, 99);
    if (r < 25)      cur_ms += $urandom_range(0, 2);
    else if (r < 75) cur_ms += $urandom_range(0, 4000);
    else if (r < 90) cur_ms += $urandom_range(40000, 50000);
    else if (r < 97) cur_ms -= $urandom_range(0, 2000);
    else             cur_ms = $urandom;
    it.now_ms = cur_ms;

    if ((it.kind == KIND_LEARN || it.kind == KIND_LOOKUP) && $urandom_range(0, 99) < 85)
      it.node_id = id_pool[$urandom_range(0, ID_POOL - 1)];

    if ((it.kind == KIND_LOOKUP || it.kind == KIND_COUNT) && tbl.count > 0 &&
        $urandom_range(0, 99) < 15) begin
      k    = $urandom_range(0, tbl.count - 1);
      offs = $urandom_range(0, 2);
      if (it.kind == KIND_LOOKUP) it.node_id = tbl.ids[k];
      it.now_ms = tbl.seen[k] + tbl.limit + offs - 1;
    end
    return it;
  endfunction

  initial begin
    rst          = 1'b1;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    hold_left    = 0;
    cur_ms       = '0;
    tbl          = new();
    set_idling(18, 69);
    foreach (id_pool[i]) id_pool[i] = {$urandom, $urandom};
    id_pool[0] = '0;
    id_pool[1] = '1;

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset value of the limit
    reg_check();

    // Directed: empty table, fill, tie-break on eviction, update, age boundary.
    offer(KIND_READ,   '0, '0, '0, '0, 4'd0);    // read out of range
    offer(KIND_COUNT,  '0, '0, '0, '0, 4'd0);    // count on an empty table
    offer(KIND_LOOKUP, '0, '0, '0, '0, 4'd0);    // lookup miss
    // slot 0: largest time unsigned, although recent once wrapped
    offer(KIND_LEARN, '1, '1, '1, 32'hFFFF_FFF0, '1);
    offer(KIND_LEARN, '0, '0, '0, 32'd100, 4'd0);
    for (int i = 2; i < TABLE_DEPTH; i++)
      offer(KIND_LEARN, 64'hA5A5_0000_0000_0000 | i, 32'hC0A8_0000 | i, PORT_W'(4000 + i),
            32'd100, 4'd0);
    // full: slots 1..15 tie at 100, lowest index goes
    offer(KIND_LEARN, 64'h8000_0000_0000_0001, 32'h0102_0304, 16'h8000, 32'd200, 4'd5);
    // known id: update in place, no replacement
    offer(KIND_LEARN, '1, 32'h0A00_0001, 16'd5000, 32'd1000, 4'd0);
    offer(KIND_LOOKUP, '1, '0, '0, 32'd46000, 4'd0);   // age equals the limit: fresh
    offer(KIND_LOOKUP, '1, '0, '0, 32'd46001, 4'd0);   // one past it
    offer(KIND_COUNT,  '0, '0, '0, 32'd45100, 4'd0);   // age at the limit is not live
    offer(KIND_READ,   '0, '0, '0, '0, 4'd15);
    offer(KIND_READ,   '0, '0, '0, '0, 4'd0);
    offer(KIND_LOOKUP, '0, '0, '0, 32'd300, 4'd0);     // evicted id
    cur_ms = 32'd46001;

    // Random phases over several limits and idling patterns.
    for (int p = 0; p < PHASES; p++) begin
      drain_results();
      case (p)
        0: reg_write(FRESH_ADDR, '0);            // fresh only at age zero, none live
        1: reg_write(FRESH_ADDR, 32'd1);
        2: begin
          reg_write(FRESH_ADDR, '1);
          reg_write(SPARE_ADDR, $urandom);
        end
        3: reg_write(FRESH_ADDR, $urandom | 32'd1);
        4: reg_write(FRESH_ADDR, FRESH_RESET);
        default: reg_write(FRESH_ADDR, $urandom_range(1, 100000));
      endcase
      case (p % 3)
        0: set_idling(18, 69);
        1: set_idling(69, 18);
        default: set_idling(0, 0);
      endcase
      for (int j = 0; j < 4; j++) id_pool[$urandom_range(2, ID_POOL - 1)] = {$urandom, $urandom};

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        send_item(make_item());
        // receiver stops for a long stretch while requests keep coming
        if (p == 3 && n == 40) hold_left = HOLD_CYCLES;
        // sender pauses until the block has returned everything
        if (p == 1 && n == 60) drain_results();
      end
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tbl.mismatches == 0 && tbl.awaited.size() == 0)
      $display("** peer_table_oldest_eviction: PASSED **");
    else
      $display("** peer_table_oldest_eviction: FAILED **");
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/ptoe_pkg.sv
hw/rtl/ptoe_if.sv
hw/rtl/ptoe_cell.sv
hw/rtl/peer_table_oldest_eviction.sv
verif/ptoe_tb_pkg.sv
verif/tb_peer_table_oldest_eviction.sv
